@@ rtl/grid4d_multilinear_interp_scatter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 4-D grid interpolator
// Clocked checks with a synchronous reset as disable condition.
// ----------------------------------------------------------------------------
`ifndef GRID4D_MULTILINEAR_INTERP_SCATTER_ASSERT_SVH
`define GRID4D_MULTILINEAR_INTERP_SCATTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define G4MI_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define G4MI_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/g4mi_pkg.sv @@
// ----------------------------------------------------------------------------
// g4mi_pkg
// Grid sizes, derived strides and reciprocals, codes and types.
// ----------------------------------------------------------------------------
package g4mi_pkg;

  localparam int N_ANGLE1 = 16;
  localparam int N_ANGLE2 = 16;
  localparam int N_RATE1  = 16;
  localparam int N_RATE2  = 16;

  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = 16;
  localparam int CORNERS     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int A1_W = $clog2(N_ANGLE1);
  localparam int A2_W = $clog2(N_ANGLE2);
  localparam int R1_W = $clog2(N_RATE1);
  localparam int R2_W = $clog2(N_RATE2);

  // angle wrap: bias makes the index non-negative, reciprocal gives the quotient
  localparam int RECIP_SHIFT = 28;
  localparam longint A1_RECIP = ((64'd1 << RECIP_SHIFT) + N_ANGLE1 - 1) / N_ANGLE1;
  localparam longint A2_RECIP = ((64'd1 << RECIP_SHIFT) + N_ANGLE2 - 1) / N_ANGLE2;
  localparam int A1_BIAS = N_ANGLE1 * ((65536 + N_ANGLE1 - 1) / N_ANGLE1);
  localparam int A2_BIAS = N_ANGLE2 * ((65536 + N_ANGLE2 - 1) / N_ANGLE2);

  localparam logic [15:0] STRIDE1 = 16'(N_ANGLE1 % 65536);
  localparam logic [15:0] STRIDE2 = 16'((N_ANGLE1 * N_ANGLE2) % 65536);
  localparam logic [15:0] STRIDE3 = 16'((N_ANGLE1 * N_ANGLE2 * N_RATE1) % 65536);

  localparam logic signed [31:0] EDGE_RESET = -32'sd6553600;
  localparam logic [23:0]        INV_RESET  = 24'd65536;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_INTERP  = 2'd2,
    MODE_SCATTER = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_OUTSIDE_VALUE = 3'd0,
    REG_ANGLE_ORIGIN  = 3'd1,
    REG_RATE1_ORIGIN  = 3'd2,
    REG_RATE2_ORIGIN  = 3'd3,
    REG_INV_ANGLE1    = 3'd4,
    REG_INV_ANGLE2    = 3'd5,
    REG_INV_RATE1     = 3'd6,
    REG_INV_RATE2     = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_WRAP,
    ST_CORNER,
    ST_READ,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/g4mi_if.sv @@
// ----------------------------------------------------------------------------
// g4mi request and result channels
// Valid/ready streams carrying the grid request and its result.
// ----------------------------------------------------------------------------
interface g4mi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [15:0]        cell_index;
  logic signed [23:0] pos_angle1;
  logic signed [23:0] pos_angle2;
  logic signed [23:0] pos_rate1;
  logic signed [23:0] pos_rate2;
  logic signed [31:0] data_value;

  modport source (output valid, mode, cell_index, pos_angle1, pos_angle2, pos_rate1,
                  pos_rate2, data_value, input ready);
  modport sink (input valid, mode, cell_index, pos_angle1, pos_angle2, pos_rate1,
                pos_rate2, data_value, output ready);
endinterface

interface g4mi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

@@ rtl/grid4d_multilinear_interp_scatter.sv @@
// Requests: one at a time, the next taken once the last result is loaded for output;
// interpolate issues one corner per cycle through a four-stage corner pipeline,
// scatter-add a corner only while s1 and s2 are empty (store read-modify-write).
// Reset: synchronous; the store is cleared one word a cycle, all 65536 words, after reset,
// no request is taken meanwhile, configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// grid4d_multilinear_interp_scatter
// 4-D value grid with cell access, quadrilinear interpolation and scatter-add.
// ----------------------------------------------------------------------------
`include "grid4d_multilinear_interp_scatter_assert.svh"

module grid4d_multilinear_interp_scatter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [g4mi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [g4mi_pkg::CFG_DATA_W-1:0]    cfg_data,
  g4mi_in_if.sink                            request,
  g4mi_out_if.source                         result
);

  g4mi_pkg::state_t state, state_next;

  logic signed [31:0] outside_value;
  logic signed [23:0] angle_origin, rate1_origin, rate2_origin;
  logic [23:0]        inv_angle1, inv_angle2, inv_rate1, inv_rate2;

  logic [31:0] mem [g4mi_pkg::STORE_DEPTH];
  logic                        mem_we;
  logic [g4mi_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]                 mem_wdata, mem_rdata;

  logic [g4mi_pkg::ADDR_W:0]   clr_cnt;
  g4mi_pkg::mode_t             mode_r;
  logic signed [23:0]          pos_r [4];
  logic signed [31:0]          data_r;
  logic signed [31:0]          res_r;
  logic [1:0]                  step;
  logic signed [16:0]          idx [4];
  logic [15:0]                 eta [4];
  logic [16:0]                 wrap_q;
  logic [g4mi_pkg::A1_W-1:0]   m1;
  logic [g4mi_pkg::A2_W-1:0]   m2;
  logic [4:0]                  issue_cnt;
  logic signed [61:0]          acc;
  logic                        out_valid;
  logic signed [31:0]          out_value;

  logic                        accept, out_load, scatter, issue, pipe_busy;

  // ---- state machine ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= g4mi_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    request.ready = 1'b0;
    out_load      = 1'b0;
    case (state)
      g4mi_pkg::ST_CLEAR: begin
        if (clr_cnt == (g4mi_pkg::ADDR_W+1)'(g4mi_pkg::STORE_DEPTH - 1)) begin
          state_next = g4mi_pkg::ST_IDLE;
        end
      end
      g4mi_pkg::ST_IDLE: begin
        request.ready = 1'b1;
        if (request.valid) begin
          case (g4mi_pkg::mode_t'(request.mode))
            g4mi_pkg::MODE_WRITE: state_next = g4mi_pkg::ST_FINISH;
            g4mi_pkg::MODE_READ:  state_next = g4mi_pkg::ST_READ;
            default:              state_next = g4mi_pkg::ST_SPLIT;
          endcase
        end
      end
      g4mi_pkg::ST_SPLIT: begin
        if (step == 2'd3) begin
          state_next = g4mi_pkg::ST_WRAP;
        end
      end
      g4mi_pkg::ST_WRAP: begin
        if (step == 2'd3) begin
          state_next = g4mi_pkg::ST_CORNER;
        end
      end
      g4mi_pkg::ST_CORNER: begin
        if (issue_cnt == 5'(g4mi_pkg::CORNERS) && !pipe_busy) begin
          state_next = g4mi_pkg::ST_FINISH;
        end
      end
      g4mi_pkg::ST_READ: begin
        state_next = g4mi_pkg::ST_FINISH;
      end
      g4mi_pkg::ST_FINISH: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = g4mi_pkg::ST_IDLE;
        end
      end
      default: state_next = g4mi_pkg::ST_CLEAR;
    endcase
  end

  assign accept  = request.valid && request.ready;
  assign scatter = (mode_r == g4mi_pkg::MODE_SCATTER);

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      outside_value <= g4mi_pkg::EDGE_RESET;
      angle_origin  <= '0;
      rate1_origin  <= '0;
      rate2_origin  <= '0;
      inv_angle1    <= g4mi_pkg::INV_RESET;
      inv_angle2    <= g4mi_pkg::INV_RESET;
      inv_rate1     <= g4mi_pkg::INV_RESET;
      inv_rate2     <= g4mi_pkg::INV_RESET;
    end else if (cfg_we) begin
      case (g4mi_pkg::cfg_reg_t'(cfg_index))
        g4mi_pkg::REG_OUTSIDE_VALUE: outside_value <= cfg_data;
        g4mi_pkg::REG_ANGLE_ORIGIN:  angle_origin  <= cfg_data[23:0];
        g4mi_pkg::REG_RATE1_ORIGIN:  rate1_origin  <= cfg_data[23:0];
        g4mi_pkg::REG_RATE2_ORIGIN:  rate2_origin  <= cfg_data[23:0];
        g4mi_pkg::REG_INV_ANGLE1:    inv_angle1    <= cfg_data[23:0];
        g4mi_pkg::REG_INV_ANGLE2:    inv_angle2    <= cfg_data[23:0];
        g4mi_pkg::REG_INV_RATE1:     inv_rate1     <= cfg_data[23:0];
        g4mi_pkg::REG_INV_RATE2:     inv_rate2     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // ---- axis split: one axis a cycle through a shared multiplier ----
  logic signed [23:0] sel_origin;
  logic [23:0]        sel_inv;
  logic signed [24:0] split_d;
  logic signed [49:0] split_y;

  always_comb begin
    case (step)
      2'd0:    begin sel_origin = angle_origin; sel_inv = inv_angle1; end
      2'd1:    begin sel_origin = angle_origin; sel_inv = inv_angle2; end
      2'd2:    begin sel_origin = rate1_origin; sel_inv = inv_rate1;  end
      default: begin sel_origin = rate2_origin; sel_inv = inv_rate2;  end
    endcase
  end

  assign split_d = 25'(pos_r[step]) - 25'(sel_origin);
  assign split_y = split_d * $signed({1'b0, sel_inv});

  // ---- angle wrap: quotient by reciprocal, then remainder ----
  logic [18:0] wrap_sum;
  logic [17:0] wrap_u;
  logic [44:0] wrap_prod;
  logic [26:0] wrap_qn;
  logic [17:0] wrap_r;

  assign wrap_sum  = step[1] ? (19'(idx[1]) + 19'(g4mi_pkg::A2_BIAS))
                             : (19'(idx[0]) + 19'(g4mi_pkg::A1_BIAS));
  assign wrap_u    = wrap_sum[17:0];
  assign wrap_prod = step[1] ? (45'(wrap_u) * 45'(g4mi_pkg::A2_RECIP))
                             : (45'(wrap_u) * 45'(g4mi_pkg::A1_RECIP));
  assign wrap_qn   = step[1] ? (27'(wrap_q) * 27'(g4mi_pkg::N_ANGLE2))
                             : (27'(wrap_q) * 27'(g4mi_pkg::N_ANGLE1));
  assign wrap_r    = wrap_u - wrap_qn[17:0];

  // ---- corner stage 0: indices, address, pair weights ----
  logic [3:0]                c_sel;
  logic [16:0]               f [4];
  logic [g4mi_pkg::A1_W-1:0] c_a1;
  logic [g4mi_pkg::A2_W-1:0] c_a2;
  logic signed [17:0]        c_r1, c_r2;
  logic                      c_inside;
  logic [31:0]               c_addr_full;
  logic [33:0]               c_wa_full, c_wr_full;

  assign c_sel = issue_cnt[3:0];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      f[k] = c_sel[3-k] ? {1'b0, eta[k]} : (17'd65536 - {1'b0, eta[k]});
    end
  end

  assign c_a1 = !c_sel[3] ? m1 :
                (m1 == g4mi_pkg::A1_W'(g4mi_pkg::N_ANGLE1 - 1)) ? '0 : m1 + 1'b1;
  assign c_a2 = !c_sel[2] ? m2 :
                (m2 == g4mi_pkg::A2_W'(g4mi_pkg::N_ANGLE2 - 1)) ? '0 : m2 + 1'b1;
  assign c_r1 = 18'(idx[2]) + 18'(c_sel[1]);
  assign c_r2 = 18'(idx[3]) + 18'(c_sel[0]);
  assign c_inside = (c_r1 >= 0) && (c_r1 < 18'(g4mi_pkg::N_RATE1)) &&
                    (c_r2 >= 0) && (c_r2 < 18'(g4mi_pkg::N_RATE2));
  assign c_addr_full = 32'(c_a1) + 32'(g4mi_pkg::STRIDE1) * 32'(c_a2) +
                       32'(g4mi_pkg::STRIDE2) * 32'(c_r1[g4mi_pkg::R1_W-1:0]) +
                       32'(g4mi_pkg::STRIDE3) * 32'(c_r2[g4mi_pkg::R2_W-1:0]);
  assign c_wa_full = 34'(f[0]) * 34'(f[1]) + 34'd32768;
  assign c_wr_full = 34'(f[2]) * 34'(f[3]) + 34'd32768;

  // ---- corner pipeline registers ----
  logic                        s1_valid, s2_valid, s3_valid;
  logic                        s1_inside, s2_inside, s3_inside;
  logic [g4mi_pkg::ADDR_W-1:0] s1_addr, s2_addr, s3_addr;
  logic [16:0]                 s1_wa, s1_wr;
  logic [24:0]                 s2_w;
  logic [33:0]                 w_full;
  logic signed [31:0]          mult_a;
  logic signed [57:0]          term_next, s3_term;
  logic signed [31:0]          s3_old;

  assign pipe_busy = s1_valid || s2_valid || s3_valid;
  assign issue = (state == g4mi_pkg::ST_CORNER) && (issue_cnt != 5'(g4mi_pkg::CORNERS)) &&
                 !(scatter && (s1_valid || s2_valid));

  assign w_full    = 34'(s1_wa) * 34'(s1_wr) + 34'd128;
  assign mult_a    = scatter ? data_r : (s2_inside ? mem_rdata : outside_value);
  assign term_next = mult_a * $signed({1'b0, s2_w});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_inside <= c_inside;
    s1_addr   <= c_addr_full[g4mi_pkg::ADDR_W-1:0];
    s1_wa     <= c_wa_full[32:16];
    s1_wr     <= c_wr_full[32:16];
    s2_inside <= s1_inside;
    s2_addr   <= s1_addr;
    s2_w      <= w_full[32:8];
    s3_inside <= s2_inside;
    s3_addr   <= s2_addr;
    s3_term   <= term_next;
    s3_old    <= mem_rdata;
  end

  // ---- scatter update ----
  logic signed [57:0] sc_rnd;
  logic signed [33:0] sc_add;
  logic signed [34:0] sc_sum;
  logic signed [31:0] sc_new;

  assign sc_rnd = s3_term + 58'sd8388608;
  assign sc_add = 34'(sc_rnd >>> 24);
  assign sc_sum = 35'(s3_old) + 35'(sc_add);
  assign sc_new = (sc_sum > 35'sd2147483647)  ? 32'sh7FFFFFFF :
                  (sc_sum < -35'sd2147483648) ? 32'sh80000000 : sc_sum[31:0];

  // ---- interpolation result ----
  logic signed [61:0] fin_rnd;
  logic signed [37:0] fin_sh;
  logic signed [31:0] fin_sat;

  assign fin_rnd = acc + 62'sd8388608;
  assign fin_sh  = 38'(fin_rnd >>> 24);
  assign fin_sat = (fin_sh > 38'sd2147483647)  ? 32'sh7FFFFFFF :
                   (fin_sh < -38'sd2147483648) ? 32'sh80000000 : fin_sh[31:0];

  // ---- datapath sequencing ----
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      step      <= '0;
      issue_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == g4mi_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept) begin
        step      <= '0;
        issue_cnt <= '0;
      end else if (state == g4mi_pkg::ST_SPLIT || state == g4mi_pkg::ST_WRAP) begin
        step <= step + 1'b1;
      end
      if (issue) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= g4mi_pkg::mode_t'(request.mode);
      pos_r[0] <= request.pos_angle1;
      pos_r[1] <= request.pos_angle2;
      pos_r[2] <= request.pos_rate1;
      pos_r[3] <= request.pos_rate2;
      data_r   <= request.data_value;
      res_r    <= request.data_value;
      acc      <= '0;
    end
    if (state == g4mi_pkg::ST_READ) begin
      res_r <= mem_rdata;
    end
    if (state == g4mi_pkg::ST_SPLIT) begin
      idx[step] <= split_y[48:32];
      eta[step] <= split_y[31:16];
    end
    if (state == g4mi_pkg::ST_WRAP) begin
      case (step)
        2'd0, 2'd2: wrap_q <= wrap_prod[44:28];
        2'd1:       m1     <= wrap_r[g4mi_pkg::A1_W-1:0];
        default:    m2     <= wrap_r[g4mi_pkg::A2_W-1:0];
      endcase
    end
    if (s3_valid && !scatter) begin
      acc <= acc + 62'(s3_term);
    end
    if (out_load) begin
      case (mode_r)
        g4mi_pkg::MODE_INTERP:  out_value <= fin_sat;
        g4mi_pkg::MODE_SCATTER: out_value <= '0;
        default:                out_value <= res_r;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.result_value = out_value;

  // ---- value store ----
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s3_addr;
    mem_wdata = sc_new;
    if (state == g4mi_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt[g4mi_pkg::ADDR_W-1:0];
      mem_wdata = '0;
    end else if (accept && g4mi_pkg::mode_t'(request.mode) == g4mi_pkg::MODE_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = request.cell_index;
      mem_wdata = request.data_value;
    end else if (state == g4mi_pkg::ST_CORNER && s3_valid && scatter && s3_inside) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = (state == g4mi_pkg::ST_CORNER) ? s1_addr : request.cell_index;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // ---- assertions ----
  `G4MI_IMPLY(a_clear_writes_zero, clk, rst, state == g4mi_pkg::ST_CLEAR,
              mem_we && mem_wdata == '0, "clearing pass must write zero every cycle")
  `G4MI_NEXT(a_scatter_interlock, clk, rst, scatter && s1_valid && state == g4mi_pkg::ST_CORNER,
             !s1_valid, "scatter corners must not overlap in the read stage")
  `G4MI_IMPLY(a_idle_pipe_empty, clk, rst, state == g4mi_pkg::ST_IDLE,
              !s1_valid && !s2_valid && !s3_valid, "corner pipeline busy while idle")
  `G4MI_IMPLY(a_corner_write_src, clk, rst, mem_we && state == g4mi_pkg::ST_CORNER,
              s3_valid && s3_inside && scatter, "store write without an inside scatter corner")

endmodule
